// File: src/avs_pkg.sv
// ----------------------------------------------------------------------------
// avs_pkg
// Shared types and constants for the autorepeat value setter: payload words,
// the configuration register set and the register indexes.
// ----------------------------------------------------------------------------
package avs_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_SIZE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VALUE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VALUE      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_TICKS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_DELAY     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_INTERVAL = 3'd5;

  // action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // interval shrink thresholds and floor
  localparam logic [6:0] IVL_THRESH_FINE   = 7'd92;  // 100 - 8
  localparam logic [6:0] IVL_THRESH_MEDIUM = 7'd84;  // 100 - 16
  localparam logic [6:0] IVL_THRESH_COARSE = 7'd68;  // 100 - 32
  localparam logic [6:0] IVL_FLOOR         = 7'd10;

  typedef struct packed {
    logic              action;
    logic signed [15:0] start_value;
    logic              touch_up;
    logic              touch_down;
    logic              touch_ok;
  } in_t;

  typedef struct packed {
    logic signed [15:0] current_value;
    logic              value_changed;
    logic              finished;
    logic              start_error;
  } out_t;

  typedef struct packed {
    logic [7:0]         step_size;
    logic signed [15:0] min_value;
    logic signed [15:0] max_value;
    logic [15:0]        release_ticks;
    logic [15:0]        hold_delay_ticks;
    logic [6:0]         start_interval;
  } cfg_t;

endpackage

// File: src/avs_cfg_regs.sv
// ----------------------------------------------------------------------------
// avs_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module avs_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [avs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [avs_pkg::CFG_DATA_W-1:0]    cfg_data,
  output avs_pkg::cfg_t                     cfg
);
  import avs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_size        <= 8'd1;
      cfg_r.min_value        <= 16'sd0;
      cfg_r.max_value        <= 16'sd999;
      cfg_r.release_ticks    <= 16'd100;
      cfg_r.hold_delay_ticks <= 16'd500;
      cfg_r.start_interval   <= 7'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_SIZE:      cfg_r.step_size        <= cfg_data[7:0];
        CFG_MIN_VALUE:      cfg_r.min_value        <= $signed(cfg_data);
        CFG_MAX_VALUE:      cfg_r.max_value        <= $signed(cfg_data);
        CFG_RELEASE_TICKS:  cfg_r.release_ticks    <= cfg_data;
        CFG_HOLD_DELAY:     cfg_r.hold_delay_ticks <= cfg_data;
        CFG_START_INTERVAL: cfg_r.start_interval   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/avs_core.sv
// ----------------------------------------------------------------------------
// avs_core
// Session state and the per-word step logic: key sampling, hold timing,
// accelerating repeat and saturating value steps.
// ----------------------------------------------------------------------------
module avs_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  avs_pkg::in_t   item,
  input  avs_pkg::cfg_t  cfg,
  output avs_pkg::out_t  res
);
  import avs_pkg::*;

  typedef enum logic [2:0] {
    MODE_STOPPED = 3'd0,
    MODE_IDLE    = 3'd1,
    MODE_UP      = 3'd2,
    MODE_DOWN    = 3'd3,
    MODE_OK      = 3'd4
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic signed [15:0] held_r, held_nxt;
  logic [15:0]        touch_r, touch_nxt;
  logic [15:0]        press_r, press_nxt;
  logic [15:0]        repeat_r, repeat_nxt;
  logic [6:0]         ivl_r, ivl_nxt;

  logic               changed;
  logic               done;
  logic               err;
  logic               touched;
  logic               dir_up;
  logic signed [15:0] stepped;
  logic [15:0]        touch_cnt;
  logic [15:0]        press_cnt;
  logic [15:0]        repeat_cnt;

  function automatic logic [15:0] inc_sat(input logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  // one step with the limit check and 16-bit saturation
  function automatic logic signed [15:0] step_value(
    input logic signed [15:0] v,
    input logic               up,
    input cfg_t               c
  );
    logic signed [16:0] sum;
    logic signed [16:0] stp;
    stp = $signed({9'b0, c.step_size});
    if (up) begin
      sum = {v[15], v} + stp;
      if (v >= c.max_value) return v;
      return (sum > 17'sd32767) ? 16'sh7FFF : sum[15:0];
    end else begin
      sum = {v[15], v} - stp;
      if (v <= c.min_value) return v;
      return (sum < -17'sd32768) ? 16'sh8000 : sum[15:0];
    end
  endfunction

  function automatic logic [6:0] shrink(input logic [6:0] r);
    logic [6:0]        dec;
    logic signed [7:0] t;
    if (r > IVL_THRESH_FINE)        dec = 7'd1;
    else if (r > IVL_THRESH_MEDIUM) dec = 7'd2;
    else if (r > IVL_THRESH_COARSE) dec = 7'd4;
    else                            dec = 7'd8;
    t = $signed({1'b0, r}) - $signed({1'b0, dec});
    if (t < $signed({1'b0, IVL_FLOOR})) return IVL_FLOOR;
    return t[6:0];
  endfunction

  always_comb begin
    mode_nxt   = mode_r;
    held_nxt   = held_r;
    touch_nxt  = touch_r;
    press_nxt  = press_r;
    repeat_nxt = repeat_r;
    ivl_nxt    = ivl_r;
    changed    = 1'b0;
    done       = 1'b0;
    err        = 1'b0;
    touch_cnt  = 16'd0;
    press_cnt  = inc_sat(press_r);
    repeat_cnt = inc_sat(repeat_r);

    dir_up  = (mode_r == MODE_IDLE) ? item.touch_up : (mode_r == MODE_UP);
    stepped = step_value(held_r, dir_up, cfg);

    case (mode_r)
      MODE_UP:   touched = item.touch_up;
      MODE_DOWN: touched = item.touch_down;
      default:   touched = item.touch_ok;
    endcase

    if (item.action == ACT_START) begin
      if (item.start_value[15]) begin
        err = 1'b1;
      end else begin
        held_nxt   = item.start_value;
        mode_nxt   = MODE_IDLE;
        touch_nxt  = 16'd0;
        press_nxt  = 16'd0;
        repeat_nxt = 16'd0;
        ivl_nxt    = cfg.start_interval;
      end
    end else begin
      case (mode_r)
        MODE_IDLE: begin
          if (item.touch_up || item.touch_down || item.touch_ok) begin
            touch_nxt  = 16'd0;
            press_nxt  = 16'd0;
            repeat_nxt = 16'd0;
            ivl_nxt    = cfg.start_interval;
            if (item.touch_up) begin
              mode_nxt = MODE_UP;
            end else if (item.touch_down) begin
              mode_nxt = MODE_DOWN;
            end else begin
              mode_nxt = MODE_OK;
            end
            if (item.touch_up || item.touch_down) begin
              held_nxt = stepped;
              changed  = (stepped != held_r);
            end
          end
        end
        MODE_UP, MODE_DOWN, MODE_OK: begin
          touch_cnt = touched ? 16'd0 : inc_sat(touch_r);
          touch_nxt = touch_cnt;
          if (touch_cnt > cfg.release_ticks) begin
            if (mode_r == MODE_OK) begin
              done     = 1'b1;
              mode_nxt = MODE_STOPPED;
            end else begin
              mode_nxt = MODE_IDLE;
            end
          end else if (mode_r != MODE_OK) begin
            press_nxt  = press_cnt;
            repeat_nxt = repeat_cnt;
            if (press_cnt > cfg.hold_delay_ticks && repeat_cnt > {9'b0, ivl_r}) begin
              held_nxt   = stepped;
              changed    = (stepped != held_r);
              repeat_nxt = 16'd0;
              ivl_nxt    = shrink(ivl_r);
            end
          end
        end
        default: ;
      endcase
    end

    res.current_value = held_nxt;
    res.value_changed = changed;
    res.finished      = done;
    res.start_error   = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_STOPPED;
      held_r   <= 16'sd0;
      touch_r  <= 16'd0;
      press_r  <= 16'd0;
      repeat_r <= 16'd0;
      ivl_r    <= 7'd100;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      touch_r  <= touch_nxt;
      press_r  <= press_nxt;
      repeat_r <= repeat_nxt;
      ivl_r    <= ivl_nxt;
    end
  end

  // ok release always closes the session
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.finished |=> mode_r == MODE_STOPPED)
    else $error("session still open after finished");

  // a refused start leaves the held value alone
  a_err_keeps_value: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.start_error |=> $stable(held_r) && $stable(mode_r))
    else $error("refused start altered state");

  // only ticks move the value
  a_change_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.value_changed |-> item.action == ACT_TICK && mode_r != MODE_STOPPED)
    else $error("value stepped outside a tick in a session");

  // the repeat interval never drops under the floor once shrunk
  a_ivl_floor: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.action == ACT_TICK && repeat_nxt == 16'd0 && repeat_r != 16'd0 &&
    (mode_r == MODE_UP || mode_r == MODE_DOWN) |=> ivl_r >= IVL_FLOOR)
    else $error("repeat interval below floor");

endmodule

// File: src/accelerating_autorepeat_value_setter.sv
// ----------------------------------------------------------------------------
// accelerating_autorepeat_value_setter
// Up/down/ok key value setter with accelerating auto-repeat.
// An accepted word passes the input register, then the result register, and
// waits in the input register while a full result is not taken. Throughput:
// one word per cycle when not stalled; the session state updates in one pass.
// Reset (rst_n low, synchronous): state and control registers are reset, the
// session is stopped and both pipeline stages are empty.
// ----------------------------------------------------------------------------
module accelerating_autorepeat_value_setter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  avs_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output avs_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [avs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [avs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import avs_pkg::*;

  cfg_t cfg;
  in_t  stage_r;
  logic stage_valid_r;
  out_t out_r;
  logic out_valid_r;
  out_t res;
  logic advance;

  avs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  avs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (stage_r),
    .cfg   (cfg),
    .res   (res)
  );

  // staged word moves on when the result register is free or being emptied
  assign advance  = stage_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stage_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid_r <= 1'b1;
    end else if (advance) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
